// ----- rtl/core/sqw_pkg.sv -----
// Package for the square-wave channel with sweep: request and register codes,
// the length load table, the duty patterns and the sweep target arithmetic.
// No dependencies.
`default_nettype none

package sqw_pkg;

  localparam int unsigned PeriodW = 11;
  localparam int unsigned LengthW = 8;

  typedef enum logic [1:0] {
    REQ_REG_WRITE = 2'd0,
    REQ_ENABLE    = 2'd1,
    REQ_TIMER     = 2'd2,
    REQ_HALF      = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    REG_DUTY   = 2'd0,
    REG_SWEEP  = 2'd1,
    REG_PER_LO = 2'd2,
    REG_PER_HI = 2'd3
  } reg_index_t;

  // Periods below this value mute the channel.
  localparam logic [PeriodW-1:0] MinPeriod = PeriodW'(8);

  typedef struct packed {
    logic               gate;
    logic               muted;
    logic               length_active;
    logic [PeriodW-1:0] period;
  } result_t;

  // Length counter load values, indexed by bits 7:3 of a period-high write.
  function automatic logic [LengthW-1:0] length_lookup(input logic [4:0] idx);
    logic [LengthW-1:0] v;
    unique case (idx)
      5'd0:  v = 8'd10;   5'd1:  v = 8'd254;  5'd2:  v = 8'd20;  5'd3:  v = 8'd2;
      5'd4:  v = 8'd40;   5'd5:  v = 8'd4;    5'd6:  v = 8'd80;  5'd7:  v = 8'd6;
      5'd8:  v = 8'd160;  5'd9:  v = 8'd8;    5'd10: v = 8'd60;  5'd11: v = 8'd10;
      5'd12: v = 8'd14;   5'd13: v = 8'd12;   5'd14: v = 8'd26;  5'd15: v = 8'd14;
      5'd16: v = 8'd12;   5'd17: v = 8'd16;   5'd18: v = 8'd24;  5'd19: v = 8'd18;
      5'd20: v = 8'd48;   5'd21: v = 8'd20;   5'd22: v = 8'd96;  5'd23: v = 8'd22;
      5'd24: v = 8'd192;  5'd25: v = 8'd24;   5'd26: v = 8'd72;  5'd27: v = 8'd26;
      5'd28: v = 8'd16;   5'd29: v = 8'd28;   5'd30: v = 8'd32;  default: v = 8'd30;
    endcase
    return v;
  endfunction

  // Duty pattern bit for a duty setting and a sequence step.
  function automatic logic duty_bit(input logic [1:0] sel, input logic [2:0] step);
    logic [7:0] pat;
    unique case (sel)
      2'd0:    pat = 8'b1000_0000;
      2'd1:    pat = 8'b1100_0000;
      2'd2:    pat = 8'b1111_0000;
      default: pat = 8'b0011_1111;
    endcase
    return pat[step];
  endfunction

  // Sweep target, one bit wider than the period so overflow is visible.
  function automatic logic [PeriodW:0] sweep_target(input logic [PeriodW-1:0] per,
                                                    input logic [2:0] shift,
                                                    input logic negate);
    logic [PeriodW:0] change;
    change = {1'b0, per >> shift};
    if (negate) begin
      return {1'b0, per} - change;
    end
    return {1'b0, per} + change;
  endfunction

  function automatic logic is_muted(input logic [PeriodW-1:0] per,
                                    input logic [2:0] shift,
                                    input logic negate);
    logic [PeriodW:0] tgt;
    tgt = sweep_target(per, shift, negate);
    return (per < MinPeriod) || tgt[PeriodW];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/square_wave_channel_with_sweep_top.sv -----
// Top level of the square-wave channel with sweep and length counter.
// Depends on sqw_pkg (codes, tables, sweep arithmetic).
`default_nettype none

// Usage
// The input channel (in_valid/in_ready) carries one request per transaction:
// a register write, an enable write, a timer tick or a half-frame tick,
// selected by req_type. Every request produces exactly one result transaction
// on the output channel (out_valid/out_ready) holding gate, muted,
// length_active and period, all taken from the channel state after the
// request has been applied.
// The state update and the result are computed in a single combinational
// pass and the result is registered on the edge that accepts the request.
// Throughput is one request per cycle while the output
// side keeps out_ready high; two 12-bit sweep adders in series (one on the
// old period, one on the updated period) and the mute compare set the path.
// When the receiver stalls, one further request is still taken and its
// result parked in a skid register; in_ready drops while that skid
// register is occupied, and rises again once the receiver drains it.
// Synchronous reset clears all channel state to zero (channel disabled,
// length counter empty, period zero), empties both result registers and
// holds in_ready low, so no request is taken while reset is asserted.
module square_wave_channel_with_sweep_top
  import sqw_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         req_type,
  input  wire logic [1:0]         reg_index,
  input  wire logic [7:0]         write_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    gate,
  output logic                    muted,
  output logic                    length_active,
  output logic [PeriodW-1:0]      period
);

  // Channel state.
  logic               enabled,              enabled_next;
  logic [1:0]         duty_select,          duty_select_next;
  logic               length_halt,          length_halt_next;
  logic               sweep_on,             sweep_on_next;
  logic [2:0]         sweep_reload_period,  sweep_reload_period_next;
  logic               sweep_negate,         sweep_negate_next;
  logic [2:0]         sweep_shift,          sweep_shift_next;
  logic               sweep_reload_pending, sweep_reload_pending_next;
  logic [2:0]         sweep_divider,        sweep_divider_next;
  logic [PeriodW-1:0] timer_period,         timer_period_next;
  logic [PeriodW-1:0] timer_count,          timer_count_next;
  logic [2:0]         duty_step,            duty_step_next;
  logic [LengthW-1:0] length_count,         length_count_next;

  // Output register and skid register.
  result_t out_res, skid_res, new_res;
  logic    skid_valid;

  logic accept, out_take, out_free;
  logic mute_now, mute_next;
  logic [PeriodW:0] target_now;
  logic [LengthW-1:0] length_dec;

  assign in_ready = !rst && !skid_valid;
  assign accept   = in_valid && in_ready;
  assign out_take = out_valid && out_ready;
  assign out_free = !out_valid || out_take;

  // Sweep target and mute status of the state before this request.
  assign target_now = sweep_target(timer_period, sweep_shift, sweep_negate);
  assign mute_now   = is_muted(timer_period, sweep_shift, sweep_negate);
  assign length_dec = length_count - LengthW'(1);

  always_comb begin
    enabled_next              = enabled;
    duty_select_next          = duty_select;
    length_halt_next          = length_halt;
    sweep_on_next             = sweep_on;
    sweep_reload_period_next  = sweep_reload_period;
    sweep_negate_next         = sweep_negate;
    sweep_shift_next          = sweep_shift;
    sweep_reload_pending_next = sweep_reload_pending;
    sweep_divider_next        = sweep_divider;
    timer_period_next         = timer_period;
    timer_count_next          = timer_count;
    duty_step_next            = duty_step;
    length_count_next         = length_count;

    unique case (req_type_t'(req_type))
      REQ_REG_WRITE: begin
        unique case (reg_index_t'(reg_index))
          REG_DUTY: begin
            duty_select_next = write_data[7:6];
            length_halt_next = write_data[5];
          end
          REG_SWEEP: begin
            sweep_on_next             = write_data[7];
            sweep_reload_period_next  = write_data[6:4];
            sweep_negate_next         = write_data[3];
            sweep_shift_next          = write_data[2:0];
            sweep_reload_pending_next = 1'b1;
          end
          REG_PER_LO: begin
            timer_period_next = {timer_period[PeriodW-1:8], write_data};
          end
          REG_PER_HI: begin
            timer_period_next = {write_data[2:0], timer_period[7:0]};
            if (enabled) begin
              length_count_next = length_lookup(write_data[7:3]);
            end
            duty_step_next = 3'd0;
          end
          default: begin
          end
        endcase
      end
      REQ_ENABLE: begin
        enabled_next = write_data[0];
        if (!write_data[0]) begin
          length_count_next = '0;
        end
      end
      REQ_TIMER: begin
        if (timer_count == '0) begin
          duty_step_next   = duty_step - 3'd1;
          timer_count_next = timer_period;
        end else begin
          timer_count_next = timer_count - PeriodW'(1);
        end
      end
      REQ_HALF: begin
        if (sweep_divider == 3'd0 && sweep_on && sweep_shift != 3'd0 && !mute_now) begin
          timer_period_next = target_now[PeriodW-1:0];
        end
        if (sweep_divider == 3'd0 || sweep_reload_pending) begin
          sweep_divider_next        = sweep_reload_period;
          sweep_reload_pending_next = 1'b0;
        end else begin
          sweep_divider_next = sweep_divider - 3'd1;
        end
        if (length_count != '0 && !length_halt) begin
          length_count_next = length_dec;
          if (length_dec == '0) begin
            enabled_next = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Result from the state as it stands after the request.
  assign mute_next = is_muted(timer_period_next, sweep_shift_next, sweep_negate_next);

  always_comb begin
    new_res.muted         = mute_next;
    new_res.length_active = (length_count_next != '0);
    new_res.period        = timer_period_next;
    new_res.gate          = enabled_next && !mute_next && new_res.length_active &&
                            duty_bit(duty_select_next, duty_step_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled              <= 1'b0;
      duty_select          <= '0;
      length_halt          <= 1'b0;
      sweep_on             <= 1'b0;
      sweep_reload_period  <= '0;
      sweep_negate         <= 1'b0;
      sweep_shift          <= '0;
      sweep_reload_pending <= 1'b0;
      sweep_divider        <= '0;
      timer_period         <= '0;
      timer_count          <= '0;
      duty_step            <= '0;
      length_count         <= '0;
    end else if (accept) begin
      enabled              <= enabled_next;
      duty_select          <= duty_select_next;
      length_halt          <= length_halt_next;
      sweep_on             <= sweep_on_next;
      sweep_reload_period  <= sweep_reload_period_next;
      sweep_negate         <= sweep_negate_next;
      sweep_shift          <= sweep_shift_next;
      sweep_reload_pending <= sweep_reload_pending_next;
      sweep_divider        <= sweep_divider_next;
      timer_period         <= timer_period_next;
      timer_count          <= timer_count_next;
      duty_step            <= duty_step_next;
      length_count         <= length_count_next;
    end
  end

  // Result buffering: the output register is refilled from the skid register
  // first, so results leave in order.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (accept) begin
        out_res <= new_res;
      end
    end else if (accept) begin
      skid_res <= new_res;
    end
  end

  assign gate          = out_res.gate;
  assign muted         = out_res.muted;
  assign length_active = out_res.length_active;
  assign period        = out_res.period;

  // A parked result implies the output register is full.
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a result while output register is empty");

  // A disabled channel never holds a nonzero length count.
  a_disabled_len_zero: assert property (@(posedge clk) disable iff (rst)
    !enabled |-> (length_count == '0))
    else $error("length counter nonzero while channel disabled");

  // An accepted request while the output is stalled lands in the skid register.
  a_stall_parks: assert property (@(posedge clk) disable iff (rst)
    (accept && out_valid && !out_ready) |=> skid_valid)
    else $error("request accepted during stall was not parked");

  // The gate opens only for an unmuted channel with a running length count.
  a_gate_consistent: assert property (@(posedge clk) disable iff (rst)
    (out_valid && gate) |-> (!muted && length_active))
    else $error("gate high while muted or length expired");

endmodule

`default_nettype wire

// ----- tb/tb_square_wave_channel_with_sweep_top.sv -----
// Self-checking testbench for square_wave_channel_with_sweep_top.
// Depends on sqw_pkg for the request, register and result types.
// A directed table runs first, then random note sequences are checked against the predictor.
`timescale 1ns / 100ps

module tb_square_wave_channel_with_sweep_top
  import sqw_pkg::*;
;

  // Number of random input transactions after the directed table.
  localparam int RandomItems = 1100;
  // Watchdog on the whole run, far above the slowest legal run.
  localparam int CycleLimit = 400000;
  // Cycles to wait after the last expected result, in case of a stray one.
  localparam int DrainCycles = 4;

  // Length counter load values, index 0 first.
  localparam logic [0:31][7:0] LenLoad = {
    8'd10, 8'd254, 8'd20, 8'd2, 8'd40, 8'd4, 8'd80, 8'd6,
    8'd160, 8'd8, 8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
    8'd12, 8'd16, 8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
    8'd192, 8'd24, 8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
  };

  // Duty waveforms, one row per duty setting, step 0 leftmost.
  localparam logic [0:3][0:7] DutyWave = {
    8'b0000_0001, 8'b0000_0011, 8'b0000_1111, 8'b1111_1100
  };

  typedef struct {
    req_type_t  kind;
    reg_index_t idx;
    logic [7:0] data;
    bit         fixed;
    result_t    fixed_res;
  } dir_row_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  req_type_t          req_type;
  reg_index_t         reg_index;
  logic [7:0]         write_data;
  logic               out_valid;
  logic               out_ready;
  logic               gate;
  logic               muted;
  logic               length_active;
  logic [PeriodW-1:0] period;

  square_wave_channel_with_sweep_top uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .req_type      (req_type),
    .reg_index     (reg_index),
    .write_data    (write_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .gate          (gate),
    .muted         (muted),
    .length_active (length_active),
    .period        (period)
  );

  // Shadow copy of the channel state, advanced once per accepted request.
  logic               ch_enabled;
  logic [1:0]         ch_duty;
  logic               ch_halt;
  logic               sw_on;
  logic [2:0]         sw_reload;
  logic               sw_negate;
  logic [2:0]         sw_shift;
  logic               sw_pending;
  logic [2:0]         sw_div;
  logic [PeriodW-1:0] tm_period;
  logic [PeriodW-1:0] tm_count;
  logic [2:0]         duty_pos;
  logic [LengthW-1:0] len_count;

  // Results still owed by the block, oldest first.
  result_t  pending_results[$];
  dir_row_t directed_rows[$];

  int  fail_count;
  int  sent_count;
  int  result_count;
  int  gate_high_count;
  int  muted_count;
  int  expiry_count;
  int  kind_count[4];
  int  cycle_count;
  // During calm stretches neither side inserts any gaps.
  bit  calm_phase;

  // Free-running clock, 4 ns period.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: a stuck handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t ns: timeout after %0d cycles, %0d results still owed", $time,
               cycle_count, pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Idle length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int roll;
    if (calm_phase) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end else if (roll < 98) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  // Retargeted period, one bit wider so that an overflow shows in bit 11.
  function automatic logic [PeriodW:0] swept_period();
    logic [PeriodW:0] delta;
    delta = {1'b0, tm_period >> sw_shift};
    if (sw_negate) begin
      return {1'b0, tm_period} - delta;
    end
    return {1'b0, tm_period} + delta;
  endfunction

  function automatic logic channel_silenced();
    logic [PeriodW:0] goal;
    goal = swept_period();
    return (tm_period < 11'd8) || (goal > 12'h7FF);
  endfunction

  // Applies one request to the shadow state and returns the result it produces.
  function automatic result_t step_channel(req_type_t kind, reg_index_t idx,
                                           logic [7:0] data);
    result_t          res;
    logic             silent;
    logic [PeriodW:0] goal;
    case (kind)
      REQ_REG_WRITE: begin
        case (idx)
          REG_DUTY: begin
            ch_duty = data[7:6];
            ch_halt = data[5];
          end
          REG_SWEEP: begin
            sw_on      = data[7];
            sw_reload  = data[6:4];
            sw_negate  = data[3];
            sw_shift   = data[2:0];
            sw_pending = 1'b1;
          end
          REG_PER_LO: begin
            tm_period[7:0] = data;
          end
          default: begin
            tm_period[10:8] = data[2:0];
            if (ch_enabled) begin
              len_count = LenLoad[data[7:3]];
            end
            duty_pos = 3'd0;
          end
        endcase
      end
      REQ_ENABLE: begin
        ch_enabled = data[0];
        if (!data[0]) begin
          len_count = '0;
        end
      end
      REQ_TIMER: begin
        if (tm_count == '0) begin
          duty_pos = duty_pos - 3'd1;
          tm_count = tm_period;
        end else begin
          tm_count = tm_count - 11'd1;
        end
      end
      default: begin
        goal = swept_period();
        if (sw_div == 3'd0 && sw_on && sw_shift != 3'd0 && !channel_silenced()) begin
          tm_period = goal[PeriodW-1:0];
        end
        if (sw_div == 3'd0 || sw_pending) begin
          sw_div     = sw_reload;
          sw_pending = 1'b0;
        end else begin
          sw_div = sw_div - 3'd1;
        end
        if (len_count != '0 && !ch_halt) begin
          len_count = len_count - 8'd1;
          if (len_count == '0) begin
            ch_enabled = 1'b0;
            expiry_count++;
          end
        end
      end
    endcase
    silent            = channel_silenced();
    res.gate          = ch_enabled && !silent && DutyWave[ch_duty][duty_pos] && len_count != '0;
    res.muted         = silent;
    res.length_active = len_count != '0;
    res.period        = tm_period;
    return res;
  endfunction

  function automatic void add_row(req_type_t kind, reg_index_t idx, logic [7:0] data);
    dir_row_t row;
    row.kind      = kind;
    row.idx       = idx;
    row.data      = data;
    row.fixed     = 1'b0;
    row.fixed_res = '0;
    directed_rows.push_back(row);
  endfunction

  // Row whose result is written out by hand.
  function automatic void add_checked(req_type_t kind, reg_index_t idx, logic [7:0] data,
                                      logic g, logic m, logic l, logic [PeriodW-1:0] p);
    dir_row_t row;
    row.kind                    = kind;
    row.idx                     = idx;
    row.data                    = data;
    row.fixed                   = 1'b1;
    row.fixed_res.gate          = g;
    row.fixed_res.muted         = m;
    row.fixed_res.length_active = l;
    row.fixed_res.period        = p;
    directed_rows.push_back(row);
  endfunction

  // Presents one request, holds it until the block takes it, and records
  // the result the block owes for it. A fixed result replaces the
  // prediction, but the shadow state is always advanced.
  task automatic send_request(input req_type_t kind, input reg_index_t idx,
                              input logic [7:0] data, input bit fixed,
                              input result_t fixed_res);
    int      gap;
    result_t predicted;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= kind;
    reg_index  <= idx;
    write_data <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = step_channel(kind, idx, data);
    pending_results.push_back(fixed ? fixed_res : predicted);
    kind_count[kind]++;
    sent_count++;
    calm_phase = ((sent_count / 150) % 4) == 3;
  endtask

  // A tick or a write with every field random, the ignored ones included.
  task automatic send_noise();
    send_request(req_type_t'($urandom_range(0, 3)), reg_index_t'($urandom_range(0, 3)),
                 8'($urandom_range(0, 255)), 1'b0, '0);
  endtask

  // Receiver: out_ready drops for random stretches, driven at the clock edge.
  initial begin : receiver
    int hold;
    hold = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold != 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 99) < 25) begin
          hold = pick_gap();
        end
      end
    end
  end

  // Result checker: every result transaction is compared with the oldest
  // outstanding expectation, field by field.
  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual gate %0b muted %0b",
                 $time, gate, muted);
        $display("%0t ns:   len %0b period %0d", $time, length_active, period);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        result_count++;
        if (gate) gate_high_count++;
        if (muted) muted_count++;
        if (gate !== want.gate) begin
          $display("%0t ns: gate mismatch, expected %0b, actual %0b", $time,
                   want.gate, gate);
          fail_count++;
        end
        if (muted !== want.muted) begin
          $display("%0t ns: muted mismatch, expected %0b, actual %0b", $time,
                   want.muted, muted);
          fail_count++;
        end
        if (length_active !== want.length_active) begin
          $display("%0t ns: length_active mismatch, expected %0b, actual %0b", $time,
                   want.length_active, length_active);
          fail_count++;
        end
        if (period !== want.period) begin
          $display("%0t ns: period mismatch, expected %0d, actual %0d", $time,
                   want.period, period);
          fail_count++;
        end
      end
    end
  end

  // Main sequence: reset, directed table, random note sequences, drain, verdict.
  initial begin : stimulus
    int       directed_total;
    int       body_len;
    int       roll;
    logic [7:0] data;
    dir_row_t row;

    rst        <= 1'b1;
    in_valid   <= 1'b0;
    req_type   <= REQ_REG_WRITE;
    reg_index  <= REG_DUTY;
    write_data <= 8'h00;
    fail_count      = 0;
    sent_count      = 0;
    result_count    = 0;
    gate_high_count = 0;
    muted_count     = 0;
    expiry_count    = 0;
    cycle_count     = 0;
    calm_phase      = 1'b0;
    kind_count      = '{0, 0, 0, 0};
    ch_enabled = 1'b0; ch_duty = '0; ch_halt = 1'b0;
    sw_on = 1'b0; sw_reload = '0; sw_negate = 1'b0; sw_shift = '0;
    sw_pending = 1'b0; sw_div = '0;
    tm_period = '0; tm_count = '0; duty_pos = '0; len_count = '0;

    // Directed table. Right after reset the period is zero, so the channel
    // is muted and the length counter is empty.
    add_checked(REQ_TIMER,     REG_DUTY,   8'h00, 1'b0, 1'b1, 1'b0, 11'd0);
    add_checked(REQ_HALF,      REG_PER_HI, 8'hFF, 1'b0, 1'b1, 1'b0, 11'd0);
    add_checked(REQ_ENABLE,    REG_DUTY,   8'h01, 1'b0, 1'b1, 1'b0, 11'd0);
    add_checked(REQ_REG_WRITE, REG_PER_LO, 8'hFF, 1'b0, 1'b0, 1'b0, 11'd255);
    // Full period: the upward sweep target overflows, so the channel mutes.
    add_checked(REQ_REG_WRITE, REG_PER_HI, 8'hFF, 1'b0, 1'b1, 1'b1, 11'd2047);
    // Negated sweep with a zero shift brings the target down to zero.
    add_checked(REQ_REG_WRITE, REG_SWEEP,  8'h08, 1'b0, 1'b0, 1'b1, 11'd2047);
    // Duty setting 3 is high on step 0, so the gate opens.
    add_checked(REQ_REG_WRITE, REG_DUTY,   8'hC0, 1'b1, 1'b0, 1'b1, 11'd2047);
    add_row(REQ_REG_WRITE, REG_DUTY,   8'h3F);
    add_row(REQ_HALF,      REG_SWEEP,  8'h00);
    // A period below eight mutes the channel.
    add_row(REQ_REG_WRITE, REG_PER_LO, 8'h04);
    add_checked(REQ_REG_WRITE, REG_PER_HI, 8'h00, 1'b0, 1'b1, 1'b1, 11'd4);
    add_row(REQ_TIMER,     REG_DUTY,   8'h00);
    add_row(REQ_TIMER,     REG_PER_HI, 8'hFF);
    // Upward sweep from 1024 with shift 1 until the target overflows.
    add_row(REQ_REG_WRITE, REG_PER_LO, 8'h00);
    add_row(REQ_REG_WRITE, REG_PER_HI, 8'h04);
    add_row(REQ_REG_WRITE, REG_SWEEP,  8'h91);
    add_row(REQ_HALF,      REG_DUTY,   8'h00);
    add_row(REQ_HALF,      REG_DUTY,   8'h00);
    add_row(REQ_HALF,      REG_DUTY,   8'h00);
    // Downward sweep setting (no sweep step falls due), then a short length that runs out and disables the channel.
    add_row(REQ_REG_WRITE, REG_SWEEP,  8'h9A);
    add_row(REQ_REG_WRITE, REG_DUTY,   8'h80);
    add_row(REQ_REG_WRITE, REG_PER_HI, 8'h18);
    add_row(REQ_HALF,      REG_DUTY,   8'h00);
    add_row(REQ_HALF,      REG_DUTY,   8'h00);
    // Length load while disabled is dropped; then enable, load, and disable.
    add_row(REQ_REG_WRITE, REG_PER_HI, 8'hF8);
    add_row(REQ_ENABLE,    REG_DUTY,   8'h01);
    add_row(REQ_REG_WRITE, REG_PER_HI, 8'h08);
    add_row(REQ_ENABLE,    REG_DUTY,   8'hFE);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[n]) begin
      row = directed_rows[n];
      send_request(row.kind, row.idx, row.data, row.fixed, row.fixed_res);
    end
    directed_total = sent_count;

    // Random part: each round programs a note, with steps left out now and
    // then, and lets it play through timer and half-frame ticks mixed with
    // fully random transactions.
    while (sent_count < directed_total + RandomItems) begin
      if ($urandom_range(0, 3) != 0) begin
        data = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 4) != 0) data[0] = 1'b1;
        send_request(REQ_ENABLE, reg_index_t'($urandom_range(0, 3)), data, 1'b0, '0);
      end
      if ($urandom_range(0, 3) != 0) begin
        send_request(REQ_REG_WRITE, REG_DUTY, 8'($urandom_range(0, 255)), 1'b0, '0);
      end
      if ($urandom_range(0, 3) != 0) begin
        send_request(REQ_REG_WRITE, REG_SWEEP, 8'($urandom_range(0, 255)), 1'b0, '0);
      end
      if ($urandom_range(0, 3) != 0) begin
        data = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 48))
                                           : 8'($urandom_range(0, 255));
        send_request(REQ_REG_WRITE, REG_PER_LO, data, 1'b0, '0);
      end
      if ($urandom_range(0, 3) != 0) begin
        data = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 6) != 0) data[2:0] = 3'd0;
        send_request(REQ_REG_WRITE, REG_PER_HI, data, 1'b0, '0);
      end
      body_len = $urandom_range(10, 60);
      repeat (body_len) begin
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          send_request(REQ_TIMER, reg_index_t'($urandom_range(0, 3)),
                       8'($urandom_range(0, 255)), 1'b0, '0);
        end else if (roll < 90) begin
          send_request(REQ_HALF, reg_index_t'($urandom_range(0, 3)),
                       8'($urandom_range(0, 255)), 1'b0, '0);
        end else begin
          send_noise();
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d transactions (%0d directed): %0d register writes, %0d enable writes,",
             sent_count, directed_total, kind_count[REQ_REG_WRITE], kind_count[REQ_ENABLE]);
    $display("  %0d timer ticks, %0d half-frame ticks.",
             kind_count[REQ_TIMER], kind_count[REQ_HALF]);
    $display("Checked %0d results: gate high in %0d, muted in %0d, length ran out %0d times.",
             result_count, gate_high_count, muted_count, expiry_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
